// ----- rtl/bid_pkg.sv -----
// bounded integer deque: shared types and command codes
// used by bid_ring_mem, bid_ctrl, bounded_integer_deque_unit and the verif files; no dependencies
package bid_pkg;

  localparam int WORD_W  = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_RIGHT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_LEFT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_RIGHT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_LEFT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] left_value;
    logic signed [WORD_W-1:0] right_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     op_error;
  } out_rsp_t;

endpackage

// ----- rtl/bid_ring_mem.sv -----
// ring storage of the deque: one write port, one read port, registered read
// depends on bid_pkg for the word width
module bid_ring_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [bid_pkg::WORD_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [bid_pkg::WORD_W-1:0] rd_data
);

  logic signed [bid_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/bid_ctrl.sv -----
// deque control: end indices, count, cached end words, read sequencing and
// the result register; depends on bid_pkg, drives bid_ring_mem
module bid_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bid_pkg::in_req_t                  in_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bid_pkg::out_rsp_t                 out_rsp,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic signed [bid_pkg::WORD_W-1:0] wr_data,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic signed [bid_pkg::WORD_W-1:0] rd_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  state_t                            state_r, state_nxt;
  logic [AW-1:0]                     li_r, li_nxt;
  logic [AW-1:0]                     ri_r, ri_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic signed [bid_pkg::WORD_W-1:0] lv_r, lv_nxt;
  logic signed [bid_pkg::WORD_W-1:0] rv_r, rv_nxt;
  logic                              side_r, side_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bid_pkg::out_rsp_t                 rsp_r, rsp_nxt;
  logic                              load;
  logic                              err;
  logic                              accept;
  logic                              is_empty, is_full;
  logic [CW+4:0]                     cnt_ext;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign is_empty  = (cnt_r == '0);
  assign is_full   = (cnt_r == FULL_CNT);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;
  assign wr_data   = in_req.push_value;

  always_comb begin
    state_nxt = state_r;
    li_nxt    = li_r;
    ri_nxt    = ri_r;
    cnt_nxt   = cnt_r;
    lv_nxt    = lv_r;
    rv_nxt    = rv_r;
    side_nxt  = side_r;
    wr_en     = 1'b0;
    wr_addr   = li_r;
    rd_en     = 1'b0;
    rd_addr   = li_r;
    load      = 1'b0;
    err       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.command)
            bid_pkg::CMD_PUSH_RIGHT, bid_pkg::CMD_PUSH_LEFT: begin
              if (is_full) begin
                err = 1'b1;
              end else if (is_empty) begin
                ri_nxt  = li_r;
                wr_en   = 1'b1;
                wr_addr = li_r;
                lv_nxt  = in_req.push_value;
                rv_nxt  = in_req.push_value;
                cnt_nxt = CW'(1);
              end else if (in_req.command == bid_pkg::CMD_PUSH_RIGHT) begin
                ri_nxt  = slot_next(ri_r);
                wr_en   = 1'b1;
                wr_addr = ri_nxt;
                rv_nxt  = in_req.push_value;
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                li_nxt  = slot_prev(li_r);
                wr_en   = 1'b1;
                wr_addr = li_nxt;
                lv_nxt  = in_req.push_value;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            bid_pkg::CMD_POP_RIGHT, bid_pkg::CMD_POP_LEFT: begin
              if (is_empty) begin
                err = 1'b1;
              end else if (cnt_r == CW'(1)) begin
                cnt_nxt = '0;
              end else begin
                // new end word comes back from the ring next cycle
                cnt_nxt   = cnt_r - 1'b1;
                rd_en     = 1'b1;
                state_nxt = ST_READ;
                side_nxt  = (in_req.command == bid_pkg::CMD_POP_RIGHT);
                if (in_req.command == bid_pkg::CMD_POP_RIGHT) begin
                  ri_nxt  = slot_prev(ri_r);
                  rd_addr = ri_nxt;
                end else begin
                  li_nxt  = slot_next(li_r);
                  rd_addr = li_nxt;
                end
              end
            end
            default: ;
          endcase
          load = !rd_en;
        end
      end
      ST_READ: begin
        load      = 1'b1;
        state_nxt = ST_IDLE;
        if (side_r) begin
          rv_nxt = rd_data;
        end else begin
          lv_nxt = rd_data;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_ext             = {5'b0, cnt_nxt};
    rsp_nxt.left_value  = (cnt_nxt == '0) ? '0 : lv_nxt;
    rsp_nxt.right_value = (cnt_nxt == '0) ? '0 : rv_nxt;
    rsp_nxt.entry_count = cnt_ext[4:0];
    rsp_nxt.is_empty    = (cnt_nxt == '0);
    rsp_nxt.is_full     = (cnt_nxt == FULL_CNT);
    rsp_nxt.op_error    = err;
    out_valid_nxt       = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      li_r        <= '0;
      ri_r        <= '0;
      cnt_r       <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      li_r        <= li_nxt;
      ri_r        <= ri_nxt;
      cnt_r       <= cnt_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r <= lv_nxt;
    rv_r <= rv_nxt;
    if (load) begin
      rsp_r <= rsp_nxt;
    end
  end

endmodule

// ----- rtl/bounded_integer_deque_unit.sv -----
// bounded integer deque: push, pop at either end or query, one result per request
// push, query, refused ops and pop of the last word load the result register directly;
// other pops first read the new end word from the ring memory (ST_IDLE, then ST_READ)
// one request in flight at a time; in_stall holds requests in ST_READ or while a result is stalled
// reset (rst_n low, synchronous) empties the deque; the ring itself is not cleared
// depends on bid_pkg, bid_ctrl and bid_ring_mem
module bounded_integer_deque_unit #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bid_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output bid_pkg::out_rsp_t out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [bid_pkg::WORD_W-1:0] wr_data;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic signed [bid_pkg::WORD_W-1:0] rd_data;

  bid_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  bid_ring_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

`ifndef SYNTH
  // a ring read turns into a result once ST_READ has loaded the result register
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> ##1 out_valid)
    else $error("ring read not followed by a result");

  // a pop never writes the ring, so a ring read and a ring write never coincide
  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("ring read and write in the same cycle");

  a_empty_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.is_empty) |->
      (out_rsp.left_value == '0 && out_rsp.right_value == '0 && !out_rsp.is_full))
    else $error("empty result with nonzero end words or full flag");
`endif

endmodule

// ----- verif/deque_checker.sv -----
`timescale 1ns / 1ps
// deque_checker: watches the request and result channels of the deque unit, predicts each result
// from its own copy of the ring, indices and count, and counts mismatches; needs bid_pkg
module deque_checker #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  bid_pkg::in_req_t  in_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  bid_pkg::out_rsp_t out_rsp,
  output int                mismatch_count,
  output int                pending_count
);

  logic signed [bid_pkg::WORD_W-1:0] ring_words [DEPTH];
  int unsigned                       left_slot;
  int unsigned                       right_slot;
  int unsigned                       live_words;
  bid_pkg::out_rsp_t                 expected_rsps [$];
  int                                error_total;

  function automatic bid_pkg::out_rsp_t apply_command(input bid_pkg::in_req_t req);
    bid_pkg::out_rsp_t rsp;
    logic              refused;
    refused = 1'b0;
    case (req.command)
      bid_pkg::CMD_PUSH_RIGHT, bid_pkg::CMD_PUSH_LEFT: begin
        if (live_words >= DEPTH) begin
          refused = 1'b1;
        end else if (live_words == 0) begin
          right_slot = left_slot;
          ring_words[left_slot] = req.push_value;
          live_words = 1;
        end else if (req.command == bid_pkg::CMD_PUSH_RIGHT) begin
          right_slot = (right_slot + 1) % DEPTH;
          ring_words[right_slot] = req.push_value;
          live_words++;
        end else begin
          left_slot = (left_slot + DEPTH - 1) % DEPTH;
          ring_words[left_slot] = req.push_value;
          live_words++;
        end
      end
      bid_pkg::CMD_POP_RIGHT, bid_pkg::CMD_POP_LEFT: begin
        if (live_words == 0) begin
          refused = 1'b1;
        end else if (live_words == 1) begin
          // indices stay where they are, the deque just goes empty
          live_words = 0;
        end else if (req.command == bid_pkg::CMD_POP_RIGHT) begin
          right_slot = (right_slot + DEPTH - 1) % DEPTH;
          live_words--;
        end else begin
          left_slot = (left_slot + 1) % DEPTH;
          live_words--;
        end
      end
      default: begin
      end
    endcase
    rsp.left_value  = (live_words == 0) ? '0 : ring_words[left_slot];
    rsp.right_value = (live_words == 0) ? '0 : ring_words[right_slot];
    rsp.entry_count = live_words[bid_pkg::COUNT_W-1:0];
    rsp.is_empty    = (live_words == 0);
    rsp.is_full     = (live_words >= DEPTH);
    rsp.op_error    = refused;
    return rsp;
  endfunction

  task automatic check_field(input string field,
                             input logic signed [bid_pkg::WORD_W-1:0] want,
                             input logic signed [bid_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      error_total++;
      if (error_total <= 10)
        $display("mismatch on %s: expected %0d got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    bid_pkg::out_rsp_t want;
    if (!rst_n) begin
      left_slot  = 0;
      right_slot = 0;
      live_words = 0;
      expected_rsps.delete();
      error_total = 0;
    end else begin
      // compare first: a result never belongs to a request accepted at the same edge
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("unexpected result: left %0d right %0d count %0d",
                     out_rsp.left_value, out_rsp.right_value, out_rsp.entry_count);
        end else begin
          want = expected_rsps.pop_front();
          check_field("left_value", want.left_value, out_rsp.left_value);
          check_field("right_value", want.right_value, out_rsp.right_value);
          check_field("entry_count", want.entry_count, out_rsp.entry_count);
          check_field("is_empty", want.is_empty, out_rsp.is_empty);
          check_field("is_full", want.is_full, out_rsp.is_full);
          check_field("op_error", want.op_error, out_rsp.op_error);
        end
      end
      if (in_valid && !in_stall)
        expected_rsps.push_back(apply_command(in_req));
    end
    mismatch_count <= error_total;
    pending_count  <= expected_rsps.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// testbench: drives directed and random deque requests with bursty input and a stalling
// receiver, gives the verdict; needs bid_pkg, deque_checker and the deque unit
module testbench;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1225;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam logic [bid_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [bid_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  bid_pkg::in_req_t  in_req;
  logic              out_valid;
  logic              out_stall;
  bid_pkg::out_rsp_t out_rsp;
  int                mismatch_count;
  int                pending_count;
  int                burst_left;
  int                quiet_cycles;

  bounded_integer_deque_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  deque_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rsp       (out_rsp),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one request and hold it until taken; a gap follows when the burst runs out or after the last request
  task automatic send_request(input logic [bid_pkg::CMD_W-1:0] cmd,
                              input logic signed [bid_pkg::WORD_W-1:0] word,
                              input logic last);
    in_valid <= 1'b1;
    in_req   <= '{command: cmd, push_value: word};
    do @(posedge clk); while (in_stall);
    if (last || burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 120) : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [bid_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int                          push_pct;
    int                          phase_left;
    int                          roll;
    logic [bid_pkg::CMD_W-1:0]   cmd;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    burst_left = $urandom_range(0, 20);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty refusals, single-word round trips, spare codes, fill to full, a refused push and two pops
    send_request(bid_pkg::CMD_QUERY, 32'sh12345678, 1'b0);
    send_request(bid_pkg::CMD_POP_RIGHT, '0, 1'b0);
    send_request(bid_pkg::CMD_POP_LEFT, '0, 1'b0);
    send_request(bid_pkg::CMD_PUSH_RIGHT, 32'sh7fffffff, 1'b0);
    send_request(bid_pkg::CMD_POP_LEFT, '0, 1'b0);
    send_request(bid_pkg::CMD_PUSH_LEFT, 32'sh80000000, 1'b0);
    send_request(bid_pkg::CMD_POP_RIGHT, '0, 1'b0);
    send_request(CMD_SPARE_FIRST, -1, 1'b0);
    send_request(CMD_SPARE_LAST, '0, 1'b0);
    for (int i = 0; i < DEPTH; i++)
      send_request((i % 2 == 0) ? bid_pkg::CMD_PUSH_LEFT : bid_pkg::CMD_PUSH_RIGHT,
                   (i % 3 == 0) ? ~(i << 27) : (i << 27) | i, 1'b0);
    send_request(bid_pkg::CMD_PUSH_RIGHT, -1, 1'b0);
    send_request(bid_pkg::CMD_POP_RIGHT, '0, 1'b0);
    send_request(bid_pkg::CMD_POP_LEFT, '0, 1'b0);

    // random: phases lean toward filling or draining, or stay balanced, so both ends and wraps get hit
    push_pct   = 50;
    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 50;
          default: push_pct = 20;
        endcase
      end else begin
        phase_left--;
      end
      roll = $urandom_range(0, 99);
      if (roll >= 90)
        cmd = bid_pkg::CMD_W'($urandom_range(bid_pkg::CMD_QUERY, CMD_SPARE_LAST));
      else if (roll < push_pct * 9 / 10)
        cmd = $urandom_range(0, 1) ? bid_pkg::CMD_PUSH_LEFT : bid_pkg::CMD_PUSH_RIGHT;
      else
        cmd = $urandom_range(0, 1) ? bid_pkg::CMD_POP_LEFT : bid_pkg::CMD_POP_RIGHT;
      send_request(cmd, pick_word(), n == RANDOM_ITEMS - 1);
    end

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // receiver: stall rate changes per phase, with a long hold-off now and then
  initial begin
    int phase_num;
    int phase_left;
    int stall_pct;
    int hold_left;
    out_stall  = 1'b0;
    phase_num  = 0;
    phase_left = 0;
    stall_pct  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          phase_num++;
          phase_left = $urandom_range(5, 60);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 75;
          endcase
          if (phase_num % 30 == 6)
            hold_left = HOLD_CYCLES;
        end else begin
          phase_left--;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
